FILE: sv/atcs_pkg.sv
// shared types and constants for the analog trigger calibrate and scale block
// no dependencies; imported by atcs_div and analog_trigger_calibrate_scale
`default_nettype none

package atcs_pkg;

	// field widths
	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 8;
	localparam int PHASE_W  = 2;

	// rest averaging
	localparam int ZERO_SAMPLES = 10;
	localparam int CNT_W        = 4;
	localparam int SUM_W        = 14;

	// shared divider: dividend holds the rest sample sum or (raw - rest) * 255
	localparam int DIV_W     = SAMPLE_W + LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = {LEVEL_W{1'b1}};
	localparam logic [SAMPLE_W-1:0] DEADZONE_RST = SAMPLE_W'(8);

	typedef logic [PHASE_W-1:0] phase_t;

	// reported phase codes
	localparam phase_t PH_AVG  = 2'd0;
	localparam phase_t PH_WAIT = 2'd1;
	localparam phase_t PH_CAL  = 2'd2;

	// divider request and status
	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: sv/atcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on atcs_pkg
`default_nettype none

module atcs_div import atcs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	output div_stat_t             stat,
	output logic [DIV_W-1:0]      quotient
);

	logic [SAMPLE_W-1:0]  rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [SAMPLE_W-1:0]  divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [SAMPLE_W:0]    trial;
	logic [SAMPLE_W:0]    diff;
	logic                 fits;

	// one trial subtraction per step
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

FILE: sv/analog_trigger_calibrate_scale.sv
// Analog trigger calibration and scaling. Each input transaction carries one
// 10-bit trigger sample and the end-stop switch; each yields exactly one
// output transaction. The first ten samples are averaged to find the rest
// position, the first pressed sample afterwards sets full travel, and from then
// on the level is (raw - rest) * 255 / (full - rest), or 255 while pressed.
// One item is worked at a time: a transaction that needs a division (the last
// rest sample, or a scaled level) passes through the 18-step bit-serial divider
// before it reaches the output register; any other goes there straight from
// evaluation. A new transaction is accepted once the previous result has been
// handed to the output register, even while that result still waits; the input
// is ready again in the cycle after that hand-over.
// top level; depends on atcs_pkg and atcs_div
`default_nettype none

module analog_trigger_calibrate_scale import atcs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] axis_sample,
	input  wire logic                endstop_pressed,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [LEVEL_W-1:0]       trigger_level,
	output logic                     switch_state,
	output logic                     changed,
	output logic [PHASE_W-1:0]       phase,
	input  wire logic                cfg_we,
	input  wire logic [SAMPLE_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration and calibration state
	logic [SAMPLE_W-1:0] deadzone_q;
	logic [CNT_W-1:0]    rest_count_q;
	logic [SUM_W-1:0]    rest_sum_q;
	logic [SAMPLE_W-1:0] rest_value_q;
	logic [SAMPLE_W-1:0] full_value_q;
	logic                cal_q;
	logic [LEVEL_W-1:0]  rep_level_q;
	logic                rep_switch_q;

	// held transaction
	logic [SAMPLE_W-1:0] sample_q;
	logic                pressed_q;

	// output register
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic                out_switch_q;
	logic                out_changed_q;
	phase_t              out_phase_q;

	div_req_t            div_req;
	div_stat_t           div_stat;
	logic [DIV_W-1:0]    quotient;

	logic                averaging;
	logic [SUM_W-1:0]    sum_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic                rest_done;
	logic [SAMPLE_W:0]   thresh;
	logic [SAMPLE_W-1:0] raw_snap;
	logic [SAMPLE_W-1:0] raw_clamp;
	logic                scale_zero;
	logic [SAMPLE_W-1:0] delta;
	logic [DIV_W-1:0]    product;
	logic [SAMPLE_W-1:0] span;
	logic                need_scale;
	logic                cal_nx;
	logic [LEVEL_W-1:0]  level;
	logic [LEVEL_W-1:0]  tval;
	logic                differs;
	logic                out_free;
	logic                commit;

	atcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// datapath for the held sample
	always_comb begin
		averaging  = rest_count_q < CNT_W'(ZERO_SAMPLES);
		sum_nx     = rest_sum_q + SUM_W'(sample_q);
		cnt_nx     = rest_count_q + 1'b1;
		rest_done  = averaging && (cnt_nx == CNT_W'(ZERO_SAMPLES));
		thresh     = {1'b0, rest_value_q} + {1'b0, deadzone_q};
		raw_snap   = ({1'b0, sample_q} <= thresh) ? rest_value_q : sample_q;
		raw_clamp  = (raw_snap > full_value_q) ? full_value_q : raw_snap;
		scale_zero = (full_value_q <= rest_value_q) || (raw_clamp < rest_value_q);
		delta      = raw_clamp - rest_value_q;
		product    = {delta, {LEVEL_W{1'b0}}} - DIV_W'(delta);
		span       = full_value_q - rest_value_q;
		need_scale = !averaging && cal_q && !pressed_q && !scale_zero;
		cal_nx     = cal_q || pressed_q;
		level      = scale_zero ? '0 : quotient[LEVEL_W-1:0];
		tval       = pressed_q ? LEVEL_MAX : level;
		differs    = (tval != rep_level_q) || (pressed_q != rep_switch_q);
	end

	// divider request: rest average or scaled level
	always_comb begin
		div_req.start    = (state_q == ST_EVAL) && (rest_done || need_scale);
		div_req.dividend = rest_done ? DIV_W'(sum_nx) : product;
		div_req.divisor  = rest_done ? SAMPLE_W'(ZERO_SAMPLES) : span;
	end

	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == ST_FIN) && out_free;
	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= div_req.start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q  <= axis_sample;
			pressed_q <= endstop_pressed;
		end
	end

	// calibration state, updated once per transaction; the deadzone on cfg_we
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q   <= DEADZONE_RST;
			rest_count_q <= '0;
			rest_sum_q   <= '0;
			rest_value_q <= '0;
			full_value_q <= '0;
			cal_q        <= 1'b0;
			rep_level_q  <= '0;
			rep_switch_q <= 1'b0;
		end else begin
			if (cfg_we) deadzone_q <= cfg_wdata;
			if (commit) begin
				if (averaging) begin
					rest_sum_q   <= sum_nx;
					rest_count_q <= cnt_nx;
					if (rest_done) rest_value_q <= quotient[SAMPLE_W-1:0];
				end else begin
					if (!cal_q && pressed_q) begin
						full_value_q <= raw_snap;
						cal_q        <= 1'b1;
					end
					if (cal_nx && differs) begin
						rep_level_q  <= tval;
						rep_switch_q <= pressed_q;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (averaging) begin
				out_level_q   <= rep_level_q;
				out_switch_q  <= rep_switch_q;
				out_changed_q <= 1'b0;
				out_phase_q   <= (cnt_nx < CNT_W'(ZERO_SAMPLES)) ? PH_AVG : PH_WAIT;
			end else if (cal_nx && differs) begin
				out_level_q   <= tval;
				out_switch_q  <= pressed_q;
				out_changed_q <= 1'b1;
				out_phase_q   <= PH_CAL;
			end else begin
				out_level_q   <= rep_level_q;
				out_switch_q  <= rep_switch_q;
				out_changed_q <= 1'b0;
				out_phase_q   <= cal_nx ? PH_CAL : PH_WAIT;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_level = out_level_q;
	assign switch_state  = out_switch_q;
	assign changed       = out_changed_q;
	assign phase         = out_phase_q;

`ifndef NO_ASSERTIONS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("input ready while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q |=> cal_q)
		else $error("calibration lost");

	a_changed_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && changed) |-> (phase == PH_CAL))
		else $error("change reported before calibration");
`endif

endmodule

`default_nettype wire
